@@ rtl/inflight_range_overlap_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the in-flight range overlap table
// Shorthand for clocked, reset-qualified checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INFLIGHT_RANGE_OVERLAP_TABLE_ASSERT_SVH
`define INFLIGHT_RANGE_OVERLAP_TABLE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define IROT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IROT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/irot_pkg.sv @@
// ----------------------------------------------------------------------------
// irot_pkg
// Types and constants shared by the in-flight range overlap table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irot_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = 64;
  localparam int COUNT_OUT_W = 5;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_ID_IN_USE = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } fsm_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } entry_t;

endpackage

@@ rtl/inflight_range_overlap_table.sv @@
// ----------------------------------------------------------------------------
// inflight_range_overlap_table
// Bounded table of in-flight requests with non-overlapping inclusive ranges.
// ----------------------------------------------------------------------------
// Flow: an accepted word is scanned against the table with one read per entry from
//   the entry memory, then decided in S_DECIDE; the done strobe is registered after it.
// Busy is high during the scan and the decide state, so no new word is taken then;
//   a new start is taken in the same cycle the done strobe is shown.
// Reset: synchronous rst empties the table (valid bits and count clear at once).
// The receiver cannot stall: the done strobe for each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module inflight_range_overlap_table
  import irot_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [WORD_W-1:0]      request_id,
  input  logic [WORD_W-1:0]      range_start,
  input  logic [WORD_W-1:0]      range_end,
  output logic                   done,
  output logic [2:0]             status,
  output logic [WORD_W-1:0]      duplicate_id,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Entry memory holds id and range; it has no reset, since an entry is only
  // looked at while its valid bit is set. Valid bits live in flip-flops.
  entry_t entry_mem [TABLE_ENTRIES];
  entry_t rd_data;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0] live_count;

  fsm_state_t state, state_next;

  // The accepted word is held here for the whole scan.
  logic              req_kind;
  logic [WORD_W-1:0] req_id;
  logic [WORD_W-1:0] req_lo;
  logic [WORD_W-1:0] req_hi;

  // Read address issue and the matching returned-data tag.
  logic [IDX_W-1:0] rd_ptr;
  logic             issuing;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  // Scan results gathered one entry per cycle.
  logic              best_found;
  logic [WORD_W-1:0] best_lo;
  logic [WORD_W-1:0] best_hi;
  logic [WORD_W-1:0] best_id;
  logic              id_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // Decision for the current word, used in the decide cycle.
  status_t           res_status;
  logic [WORD_W-1:0] res_dup;
  logic              do_write;
  logic              do_clear;
  logic [CNT_W-1:0]  count_next;

  logic accept;
  logic rd_live;
  logic rd_cand;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign rd_live = rd_vld && valid[rd_idx];
  // An entry is a candidate if it ends at or after the new start; the closest
  // such end is the only range that can touch the new one.
  assign rd_cand = rd_live && (rd_data.hi >= req_lo) &&
                   (!best_found || (rd_data.hi < best_hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld && (rd_idx == LAST_IDX)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Final decision: a remove reports removed or not found; an add checks overlap or duplicate, id in use, full.
  always_comb begin
    res_status = ST_ADDED;
    res_dup    = '0;
    do_write   = 1'b0;
    do_clear   = 1'b0;
    count_next = live_count;
    if (req_kind == KIND_REMOVE) begin
      if (id_hit) begin
        res_status = ST_REMOVED;
        do_clear   = 1'b1;
        count_next = live_count - CNT_W'(1);
      end else begin
        res_status = ST_NOT_FOUND;
      end
    end else if (req_lo > req_hi) begin
      res_status = ST_OVERLAP;
    end else if (best_found && (best_lo <= req_hi)) begin
      if ((best_lo <= req_lo) && (req_hi <= best_hi)) begin
        res_status = ST_DUPLICATE;
        res_dup    = best_id;
      end else begin
        res_status = ST_OVERLAP;
      end
    end else if (id_hit) begin
      res_status = ST_ID_IN_USE;
    end else if (!free_found) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_ADDED;
      do_write   = 1'b1;
      count_next = live_count + CNT_W'(1);
    end
  end

  // Memory: one registered read port for the scan, one write port for adds.
  always_ff @(posedge clk) begin
    rd_data <= entry_mem[rd_ptr];
    if ((state == S_DECIDE) && do_write) begin
      entry_mem[free_idx] <= '{id: req_id, hi: req_hi, lo: req_lo};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      rd_vld     <= 1'b0;
      valid      <= '0;
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      done   <= (state == S_DECIDE);
      rd_vld <= (state == S_SCAN) && issuing;
      if (accept) begin
        issuing <= 1'b1;
      end else if ((state == S_SCAN) && issuing && (rd_ptr == LAST_IDX)) begin
        issuing <= 1'b0;
      end
      if (state == S_DECIDE) begin
        live_count <= count_next;
        if (do_write) begin
          valid[free_idx] <= 1'b1;
        end
        if (do_clear) begin
          valid[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // Word capture, scan bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind   <= kind;
      req_id     <= request_id;
      req_lo     <= range_start;
      req_hi     <= range_end;
      rd_ptr     <= '0;
      best_found <= 1'b0;
      id_hit     <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      if (issuing && (rd_ptr != LAST_IDX)) begin
        rd_ptr <= rd_ptr + IDX_W'(1);
      end
      if (rd_cand) begin
        best_found <= 1'b1;
        best_lo    <= rd_data.lo;
        best_hi    <= rd_data.hi;
        best_id    <= rd_data.id;
      end
      if (rd_live && (rd_data.id == req_id) && !id_hit) begin
        id_hit  <= 1'b1;
        hit_idx <= rd_idx;
      end
      if (rd_vld && !valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    rd_idx <= rd_ptr;
    if (state == S_DECIDE) begin
      status       <= res_status;
      duplicate_id <= res_dup;
      entry_count  <= COUNT_OUT_W'(count_next);
    end
  end

`include "inflight_range_overlap_table_assert.svh"

  `IROT_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid) == live_count, "count mismatch")
  `IROT_ASSERT_NEXT(a_accept_goes_busy, accept, busy && (state == S_SCAN), "no scan after accept")
  `IROT_ASSERT_NEXT(a_decide_then_done, state == S_DECIDE, done && !busy, "no result")
  `IROT_ASSERT_NOW(a_read_only_in_scan, rd_vld, state == S_SCAN, "read data outside the scan")

endmodule
